// File: rtl/aaf_pkg.sv
// ----------------------------------------------------------------------------
// aaf_pkg
// Shared types, constants and helpers of the arbitrary axis frame core.
// ----------------------------------------------------------------------------
package aaf_pkg;

   localparam int AAF_SQRT_STEPS = 32;
   localparam int AAF_DIV_STEPS  = 31;
   localparam int AAF_UNIT_LAT   = 6 + AAF_SQRT_STEPS + 1 + AAF_DIV_STEPS + 1;
   localparam int AAF_CROSS_LAT  = 3;
   localparam int AAF_LAT        = 2 * AAF_UNIT_LAT + 1 + AAF_CROSS_LAT;

   localparam logic [31:0]        AAF_SMALL_Q30 = 32'h0100_0000;
   localparam logic signed [31:0] AAF_ONE_Q30   = 32'sh4000_0000;

   typedef struct packed {
      logic valid;
      logic zero;
   } aaf_flag_type;

   // left shift that brings the largest magnitude to at least 2^30
   function automatic logic [4:0] aaf_shift_count(input logic [31:0] mx);
      logic [4:0] sh;
      sh = '0;
      for (int i = 0; i < 31; i++) begin
         if (mx[i]) begin
            sh = 5'(30 - i);
         end
      end
      if (mx[31]) begin
         sh = '0;
      end
      return sh;
   endfunction

endpackage

// File: rtl/arbitrary_axis_frame_core.sv
// ----------------------------------------------------------------------------
// arbitrary_axis_frame_core
// Arbitrary axis frame: takes an extrusion normal in Q16.16 and returns the
// unit axes Ax, Ay, Az in Q2.30. One normal is accepted in every cycle (busy
// stays low) and each result word appears on the rsp_ ports, marked by
// rsp_valid; results come in input order and cannot be held off. The latency
// is set by two normalizers of 71 stages each (a one-bit-per-stage square root
// and one-bit-per-stage dividers), one axis-select stage and a three-stage
// cross product. A zero normal gives rsp_degenerate high and all nine
// components zero.
// ----------------------------------------------------------------------------
module arbitrary_axis_frame_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_normal_x,
   input  logic signed [31:0] req_normal_y,
   input  logic signed [31:0] req_normal_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_ax_x,
   output logic signed [31:0] rsp_ax_y,
   output logic signed [31:0] rsp_ax_z,
   output logic signed [31:0] rsp_ay_x,
   output logic signed [31:0] rsp_ay_y,
   output logic signed [31:0] rsp_ay_z,
   output logic signed [31:0] rsp_az_x,
   output logic signed [31:0] rsp_az_y,
   output logic signed [31:0] rsp_az_z,
   output logic               rsp_degenerate
);
   import aaf_pkg::*;

   typedef struct packed {
      logic             degen;
      logic [2:0][31:0] az;
   } dly_type;

   logic signed [32:0] n_v  [3];
   aaf_flag_type       u1_flag;
   logic signed [31:0] u1_az [3];
   logic [31:0]        abs_x, abs_y;
   logic               near_pole;

   aaf_flag_type       sel_flag_ff;
   logic signed [32:0] t_ff  [3];
   logic signed [32:0] t_in  [3];
   dly_type            sel_in;
   dly_type            dly_ff [AAF_UNIT_LAT+1];

   aaf_flag_type       u2_flag;
   logic signed [31:0] u2_ax [3];

   aaf_flag_type       cr_in_flag;
   logic signed [31:0] cr_az [3];
   aaf_flag_type       cr_flag;
   logic signed [31:0] o_ax [3];
   logic signed [31:0] o_ay [3];
   logic signed [31:0] o_az [3];

   assign busy = 1'b0;

   assign n_v[0] = 33'(req_normal_x);
   assign n_v[1] = 33'(req_normal_y);
   assign n_v[2] = 33'(req_normal_z);

   aaf_unit3 u_norm_z (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .in_v     (n_v),
      .out_flag (u1_flag),
      .out_u    (u1_az)
   );

   // axis select
   assign abs_x = u1_az[0][31] ? 32'(-u1_az[0]) : 32'(u1_az[0]);
   assign abs_y = u1_az[1][31] ? 32'(-u1_az[1]) : 32'(u1_az[1]);
   assign near_pole = (abs_x < AAF_SMALL_Q30) && (abs_y < AAF_SMALL_Q30);

   always_comb begin
      if (near_pole) begin
         t_in[0] = 33'(u1_az[2]);
         t_in[1] = '0;
         t_in[2] = -(33'(u1_az[0]));
      end else begin
         t_in[0] = -(33'(u1_az[1]));
         t_in[1] = 33'(u1_az[0]);
         t_in[2] = '0;
      end
      sel_in.degen = u1_flag.zero;
      for (int i = 0; i < 3; i++) begin
         sel_in.az[i] = u1_az[i];
      end
   end

   always_ff @(posedge clock) begin
      sel_flag_ff <= u1_flag;
      t_ff        <= t_in;
      dly_ff[0]   <= sel_in;
      for (int k = 1; k < AAF_UNIT_LAT + 1; k++) begin
         dly_ff[k] <= dly_ff[k-1];
      end
      if (reset) begin
         sel_flag_ff.valid <= 1'b0;
      end
   end

   aaf_unit3 u_norm_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sel_flag_ff.valid),
      .in_v     (t_ff),
      .out_flag (u2_flag),
      .out_u    (u2_ax)
   );

   always_comb begin
      cr_in_flag.valid = u2_flag.valid;
      cr_in_flag.zero  = dly_ff[AAF_UNIT_LAT].degen | u2_flag.zero;
      for (int i = 0; i < 3; i++) begin
         cr_az[i] = $signed(dly_ff[AAF_UNIT_LAT].az[i]);
      end
   end

   aaf_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .in_flag  (cr_in_flag),
      .in_az    (cr_az),
      .in_ax    (u2_ax),
      .out_flag (cr_flag),
      .out_ax   (o_ax),
      .out_ay   (o_ay),
      .out_az   (o_az)
   );

   assign rsp_valid      = cr_flag.valid;
   assign rsp_degenerate = cr_flag.zero;
   assign rsp_ax_x       = o_ax[0];
   assign rsp_ax_y       = o_ax[1];
   assign rsp_ax_z       = o_ax[2];
   assign rsp_ay_x       = o_ay[0];
   assign rsp_ay_y       = o_ay[1];
   assign rsp_ay_z       = o_ay[2];
   assign rsp_az_x       = o_az[0];
   assign rsp_az_y       = o_az[1];
   assign rsp_az_z       = o_az[2];

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##AAF_LAT rsp_valid)
      else $error("result word missing at fixed latency");

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_ax_x == 0 && rsp_ax_y == 0 && rsp_ax_z == 0 &&
         rsp_ay_x == 0 && rsp_ay_y == 0 && rsp_ay_z == 0 &&
         rsp_az_x == 0 && rsp_az_y == 0 && rsp_az_z == 0)
      else $error("degenerate word with nonzero axes");

   a_ax_branch : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_ax_y == 0 || rsp_ax_z == 0)
      else $error("x axis matches neither branch");

   a_az_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_az_x <= AAF_ONE_Q30 && rsp_az_x >= -AAF_ONE_Q30 &&
         rsp_az_y <= AAF_ONE_Q30 && rsp_az_y >= -AAF_ONE_Q30 &&
         rsp_az_z <= AAF_ONE_Q30 && rsp_az_z >= -AAF_ONE_Q30)
      else $error("unit normal component above one");

endmodule

// File: rtl/aaf_unit3.sv
// ----------------------------------------------------------------------------
// aaf_unit3
// Pipelined 3-vector normalizer: magnitude scaling, squares, bit-per-stage
// square root and bit-per-stage dividers, one vector per cycle.
// ----------------------------------------------------------------------------
module aaf_unit3 (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [32:0]    in_v [3],
   output aaf_pkg::aaf_flag_type out_flag,
   output logic signed [31:0]    out_u [3]
);
   import aaf_pkg::*;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][31:0] m;
   } side_type;

   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] neg;
   } dflag_type;

   side_type         s0_in, s0_ff, s1_in, s1_ff, s2_ff, s3_in, s3_ff, s4_ff;
   logic [31:0]      mx_in, mx_ff;
   logic [4:0]       sh_ff;
   logic [2:0][63:0] sq_in, sq_ff;

   logic [63:0]      rad_ff   [0:AAF_SQRT_STEPS];
   logic [33:0]      rem_ff   [0:AAF_SQRT_STEPS];
   logic [31:0]      root_ff  [0:AAF_SQRT_STEPS];
   side_type         sside_ff [0:AAF_SQRT_STEPS];

   logic [62:0]      num_in   [3];
   logic [32:0]      dd_ff    [0:AAF_DIV_STEPS];
   logic [32:0]      drem_ff  [0:AAF_DIV_STEPS][3];
   logic [30:0]      dlow_ff  [0:AAF_DIV_STEPS][3];
   logic [30:0]      dq_ff    [0:AAF_DIV_STEPS][3];
   dflag_type        dflag_ff [0:AAF_DIV_STEPS];

   aaf_flag_type     out_flag_ff;
   logic signed [31:0] out_u_in [3];
   logic signed [31:0] out_u_ff [3];

   // magnitudes and signs
   always_comb begin
      s0_in       = '0;
      s0_in.valid = in_valid;
      for (int i = 0; i < 3; i++) begin
         s0_in.neg[i] = in_v[i][32];
         s0_in.m[i]   = in_v[i][32] ? 32'(-in_v[i]) : 32'(in_v[i]);
      end
   end

   // largest magnitude
   always_comb begin
      mx_in = s0_ff.m[0];
      if (s0_ff.m[1] > mx_in) begin
         mx_in = s0_ff.m[1];
      end
      if (s0_ff.m[2] > mx_in) begin
         mx_in = s0_ff.m[2];
      end
      s1_in      = s0_ff;
      s1_in.zero = (mx_in == '0);
   end

   // scaled magnitudes
   always_comb begin
      s3_in = s2_ff;
      for (int i = 0; i < 3; i++) begin
         s3_in.m[i] = s2_ff.m[i] << sh_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = 64'(s3_ff.m[i]) * 64'(s3_ff.m[i]);
      end
   end

   always_ff @(posedge clock) begin
      s0_ff      <= s0_in;
      s1_ff      <= s1_in;
      mx_ff      <= mx_in;
      s2_ff      <= s1_ff;
      sh_ff      <= aaf_shift_count(mx_ff);
      s3_ff      <= s3_in;
      s4_ff      <= s3_ff;
      sq_ff      <= sq_in;
      rad_ff[0]  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      sside_ff[0] <= s4_ff;
      if (reset) begin
         s0_ff.valid       <= 1'b0;
         s1_ff.valid       <= 1'b0;
         s2_ff.valid       <= 1'b0;
         s3_ff.valid       <= 1'b0;
         s4_ff.valid       <= 1'b0;
         sside_ff[0].valid <= 1'b0;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 1; k <= AAF_SQRT_STEPS; k++) begin : g_sqrt
      logic [35:0] cur;
      logic [35:0] trial;
      logic [35:0] diff;
      assign cur   = {rem_ff[k-1], rad_ff[k-1][63:62]};
      assign trial = {2'b00, root_ff[k-1], 2'b01};
      assign diff  = cur - trial;
      always_ff @(posedge clock) begin
         rad_ff[k]   <= {rad_ff[k-1][61:0], 2'b00};
         sside_ff[k] <= sside_ff[k-1];
         if (cur >= trial) begin
            rem_ff[k]  <= diff[33:0];
            root_ff[k] <= {root_ff[k-1][30:0], 1'b1};
         end else begin
            rem_ff[k]  <= cur[33:0];
            root_ff[k] <= {root_ff[k-1][30:0], 1'b0};
         end
         if (reset) begin
            sside_ff[k].valid <= 1'b0;
         end
      end
   end

   // divider setup: (m * 2^31 + r) / (2 r)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {sside_ff[AAF_SQRT_STEPS].m[i], 31'b0}
                   + 63'(root_ff[AAF_SQRT_STEPS]);
      end
   end

   always_ff @(posedge clock) begin
      dd_ff[0]          <= {root_ff[AAF_SQRT_STEPS], 1'b0};
      dflag_ff[0].valid <= sside_ff[AAF_SQRT_STEPS].valid;
      dflag_ff[0].zero  <= sside_ff[AAF_SQRT_STEPS].zero;
      dflag_ff[0].neg   <= sside_ff[AAF_SQRT_STEPS].neg;
      for (int i = 0; i < 3; i++) begin
         drem_ff[0][i] <= {1'b0, num_in[i][62:31]};
         dlow_ff[0][i] <= num_in[i][30:0];
         dq_ff[0][i]   <= '0;
      end
      if (reset) begin
         dflag_ff[0].valid <= 1'b0;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 1; k <= AAF_DIV_STEPS; k++) begin : g_div
      for (genvar i = 0; i < 3; i++) begin : g_lane
         logic [33:0] cur;
         logic [33:0] diff;
         assign cur  = {drem_ff[k-1][i], dlow_ff[k-1][i][30]};
         assign diff = cur - {1'b0, dd_ff[k-1]};
         always_ff @(posedge clock) begin
            dlow_ff[k][i] <= {dlow_ff[k-1][i][29:0], 1'b0};
            if (cur >= {1'b0, dd_ff[k-1]}) begin
               drem_ff[k][i] <= diff[32:0];
               dq_ff[k][i]   <= {dq_ff[k-1][i][29:0], 1'b1};
            end else begin
               drem_ff[k][i] <= cur[32:0];
               dq_ff[k][i]   <= {dq_ff[k-1][i][29:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         dd_ff[k]    <= dd_ff[k-1];
         dflag_ff[k] <= dflag_ff[k-1];
         if (reset) begin
            dflag_ff[k].valid <= 1'b0;
         end
      end
   end

   // sign and zero vector
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dflag_ff[AAF_DIV_STEPS].zero) begin
            out_u_in[i] = '0;
         end else if (dflag_ff[AAF_DIV_STEPS].neg[i]) begin
            out_u_in[i] = -$signed({1'b0, dq_ff[AAF_DIV_STEPS][i]});
         end else begin
            out_u_in[i] = $signed({1'b0, dq_ff[AAF_DIV_STEPS][i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      out_flag_ff.valid <= dflag_ff[AAF_DIV_STEPS].valid;
      out_flag_ff.zero  <= dflag_ff[AAF_DIV_STEPS].zero;
      out_u_ff          <= out_u_in;
      if (reset) begin
         out_flag_ff.valid <= 1'b0;
      end
   end

   assign out_flag = out_flag_ff;
   assign out_u    = out_u_ff;

endmodule

// File: rtl/aaf_cross.sv
// ----------------------------------------------------------------------------
// aaf_cross
// Three-stage cross product Ay = Az x Ax with Q30 rounding and saturation.
// ----------------------------------------------------------------------------
module aaf_cross (
   input  logic                  clock,
   input  logic                  reset,
   input  aaf_pkg::aaf_flag_type in_flag,
   input  logic signed [31:0]    in_az [3],
   input  logic signed [31:0]    in_ax [3],
   output aaf_pkg::aaf_flag_type out_flag,
   output logic signed [31:0]    out_ax [3],
   output logic signed [31:0]    out_ay [3],
   output logic signed [31:0]    out_az [3]
);
   import aaf_pkg::*;

   aaf_flag_type       f1_ff, f2_ff, f3_ff;
   logic signed [31:0] az1_ff [3];
   logic signed [31:0] ax1_ff [3];
   logic signed [31:0] az2_ff [3];
   logic signed [31:0] ax2_ff [3];
   logic signed [31:0] az3_ff [3];
   logic signed [31:0] ax3_ff [3];
   logic signed [31:0] ay3_ff [3];
   logic signed [31:0] ay_in  [3];
   logic signed [63:0] p_ff   [6];
   logic signed [64:0] d_ff   [3];

   function automatic logic signed [31:0] round_q30(input logic signed [64:0] v);
      logic [64:0] mag;
      logic [34:0] q;
      logic signed [31:0] r;
      mag = v[64] ? 65'(-v) : 65'(v);
      q   = 35'((mag + 65'h2000_0000) >> 30);
      if (!v[64] && q > 35'h7fff_ffff) begin
         r = 32'sh7fff_ffff;
      end else if (v[64] && q > 35'h8000_0000) begin
         r = 32'sh8000_0000;
      end else if (v[64]) begin
         r = 32'(-$signed({1'b0, q}));
      end else begin
         r = 32'(q);
      end
      return r;
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ay_in[i] = f2_ff.zero ? 32'sh0 : round_q30(d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      f1_ff  <= in_flag;
      az1_ff <= in_az;
      ax1_ff <= in_ax;
      p_ff[0] <= in_az[1] * in_ax[2];
      p_ff[1] <= in_az[2] * in_ax[1];
      p_ff[2] <= in_az[2] * in_ax[0];
      p_ff[3] <= in_az[0] * in_ax[2];
      p_ff[4] <= in_az[0] * in_ax[1];
      p_ff[5] <= in_az[1] * in_ax[0];

      f2_ff  <= f1_ff;
      az2_ff <= az1_ff;
      ax2_ff <= ax1_ff;
      d_ff[0] <= 65'(p_ff[0]) - 65'(p_ff[1]);
      d_ff[1] <= 65'(p_ff[2]) - 65'(p_ff[3]);
      d_ff[2] <= 65'(p_ff[4]) - 65'(p_ff[5]);

      f3_ff  <= f2_ff;
      ay3_ff <= ay_in;
      for (int i = 0; i < 3; i++) begin
         az3_ff[i] <= f2_ff.zero ? 32'sh0 : az2_ff[i];
         ax3_ff[i] <= f2_ff.zero ? 32'sh0 : ax2_ff[i];
      end
      if (reset) begin
         f1_ff.valid <= 1'b0;
         f2_ff.valid <= 1'b0;
         f3_ff.valid <= 1'b0;
      end
   end

   assign out_flag = f3_ff;
   assign out_ax   = ax3_ff;
   assign out_ay   = ay3_ff;
   assign out_az   = az3_ff;

endmodule
